### hw/rtl/ppre_pkg.sv
// ppre_pkg: shared types, constants and helpers of the packed-pixel raster engine
// no dependencies; used by ppre_ctrl, ppre_datapath and the top level

package ppre_pkg;

    localparam int DEF_SCREEN_WIDTH    = 320;
    localparam int DEF_SCREEN_HEIGHT   = 200;
    localparam int DEF_ROW_PITCH_BYTES = 80;

    // stream widths: fields packed from bit 0 up, padded to whole bytes
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;

    // internal coordinate width, holds origin plus position plus extents
    localparam int EXT_W = 14;

    localparam logic [7:0] PIX_ON_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        OP_PIXEL  = 3'd0,
        OP_FILL   = 3'd1,
        OP_INVERT = 3'd2,
        OP_SCROLL = 3'd3,
        OP_READ   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_ROW,
        ST_READ,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic setup_a;
        logic setup_b;
        logic row_eval;
        logic row_step;
        logic mem_rd;
        logic mem_wr;
        logic col_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;
        logic row_ok;
        logic has_cols;
        logic last_row;
        logic last_col;
        logic out_free;
    } dp_status_t;

    // byte mask covering pixels lb..rb, leftmost pixel in bits 7..6
    function automatic logic [7:0] edge_mask(input logic [1:0] lb, input logic [1:0] rb);
        logic [2:0] lsh;
        logic [2:0] rsh;
        lsh = {lb, 1'b0};
        rsh = {2'd3 - rb, 1'b0};
        return (8'hFF >> lsh) & (8'hFF << rsh);
    endfunction

endpackage

### hw/rtl/ppre_ram.sv
// ppre_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module ppre_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ppre_ctrl.sv
// ppre_ctrl: command sequencer of the raster engine
// depends on ppre_pkg; drives ppre_datapath through ctrl_cmd_t, reads dp_status_t

module ppre_ctrl
    import ppre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SETUP_A;
                end
            end
            ST_SETUP_A: state_next = ST_SETUP_B;
            ST_SETUP_B: state_next = ST_ROW;
            ST_ROW:
            begin
                priority if (!status.active)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.row_ok && status.has_cols)
                begin
                    state_next = ST_READ;
                end
                else if (status.last_row)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ROW;
                end
            end
            ST_READ: state_next = ST_WRITE;
            ST_WRITE:
            begin
                priority if (!status.last_col)
                begin
                    state_next = ST_READ;
                end
                else if (status.last_row)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ROW;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SETUP_A: cmd.setup_a = 1'b1;
            ST_SETUP_B: cmd.setup_b = 1'b1;
            ST_ROW:
            begin
                if (status.active)
                begin
                    cmd.row_eval = 1'b1;
                    cmd.row_step = !(status.row_ok && status.has_cols) && !status.last_row;
                end
            end
            ST_READ: cmd.mem_rd = 1'b1;
            ST_WRITE:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.col_step = !status.last_col;
                cmd.row_step = status.last_col && !status.last_row;
            end
            ST_FINISH: cmd.finish = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### hw/rtl/ppre_datapath.sv
// ppre_datapath: command registers, clipping setup, row/column walk and result register
// depends on ppre_pkg; talks to ppre_ram through its ports

module ppre_datapath
    import ppre_pkg::*;
#(
    parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
    parameter int ROW_PITCH_BYTES = DEF_ROW_PITCH_BYTES
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic [IN_TDATA_W-1:0]                          s_tdata,
    input  ctrl_cmd_t                                      cmd,
    output dp_status_t                                     status,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    output logic [OUT_TDATA_W-1:0]                         m_tdata,
    output logic                                           ram_we,
    output logic [$clog2(ROW_PITCH_BYTES*SCREEN_HEIGHT)-1:0] ram_waddr,
    output logic [7:0]                                     ram_wdata,
    output logic                                           ram_re,
    output logic [$clog2(ROW_PITCH_BYTES*SCREEN_HEIGHT)-1:0] ram_raddr,
    input  logic [7:0]                                     ram_rdata
);

    localparam int PITCH_PIXELS = 4 * ROW_PITCH_BYTES;
    localparam int VIS_W        = (SCREEN_WIDTH < PITCH_PIXELS) ? SCREEN_WIDTH : PITCH_PIXELS;
    localparam int VIS_BYTES    = (VIS_W + 3) / 4;
    localparam int ADDR_W       = $clog2(ROW_PITCH_BYTES * SCREEN_HEIGHT);
    localparam int COL_W        = $clog2(ROW_PITCH_BYTES);
    localparam int ROW_W        = $clog2(SCREEN_HEIGHT);

    localparam logic signed [EXT_W-1:0] VIS_W_S     = EXT_W'(VIS_W);
    localparam logic signed [EXT_W-1:0] VIS_BYTES_S = EXT_W'(VIS_BYTES);
    localparam logic signed [EXT_W-1:0] HEIGHT_S    = EXT_W'(SCREEN_HEIGHT);
    localparam logic signed [EXT_W-1:0] ZERO_S      = '0;
    localparam logic signed [EXT_W-1:0] ONE_S       = EXT_W'(1);

    // command fields
    opcode_t                  op_reg;
    logic signed [EXT_W-1:0]  x_reg;
    logic signed [EXT_W-1:0]  y_reg;
    logic [9:0]               w_reg;
    logic [9:0]               h_reg;
    logic                     color_reg;
    logic [7:0]               dy_reg;

    // setup results
    logic signed [EXT_W-1:0]  x1_reg;
    logic signed [EXT_W-1:0]  y1_reg;
    logic signed [EXT_W-1:0]  bxe_reg;
    logic signed [EXT_W-1:0]  yl_reg;

    // walk state
    logic signed [EXT_W-1:0]  row_reg;
    logic signed [EXT_W-1:0]  row_last_reg;
    logic [COL_W-1:0]         col_reg;
    logic [COL_W-1:0]         col_lo_reg;
    logic [COL_W-1:0]         col_last_reg;
    logic [1:0]               edge_lo_reg;
    logic [1:0]               edge_hi_reg;
    logic                     has_cols_reg;
    logic                     colclip_reg;
    logic                     active_reg;
    logic                     clip_reg;
    logic [ADDR_W-1:0]        dst_base_reg;
    logic [ADDR_W-1:0]        src_base_reg;
    logic [7:0]               rd_reg;

    // result register
    logic                     out_valid_reg;
    logic [7:0]               out_rd_reg;
    logic                     out_clip_reg;

    // input item decode: opcode, origin_x, origin_y, pos_x, pos_y,
    // rect_width, rect_height, color, scroll_rows
    logic signed [10:0] in_ox;
    logic signed [10:0] in_oy;
    logic signed [10:0] in_px;
    logic signed [10:0] in_py;
    logic signed [EXT_W-1:0] x_sum;
    logic signed [EXT_W-1:0] y_sum;

    assign in_ox = $signed(s_tdata[13:3]);
    assign in_oy = $signed(s_tdata[24:14]);
    assign in_px = $signed(s_tdata[35:25]);
    assign in_py = $signed(s_tdata[46:36]);
    assign x_sum = EXT_W'(in_ox) + EXT_W'(in_px);
    assign y_sum = EXT_W'(in_oy) + EXT_W'(in_py);

    logic signed [EXT_W-1:0] w_s;
    logic signed [EXT_W-1:0] h_s;
    logic signed [EXT_W-1:0] dy_s;
    logic signed [EXT_W-1:0] bx;
    logic signed [EXT_W-1:0] cnt_s;

    assign w_s   = $signed(EXT_W'(w_reg));
    assign h_s   = $signed(EXT_W'(h_reg));
    assign dy_s  = $signed(EXT_W'(dy_reg));
    assign bx    = x_reg >>> 2;
    assign cnt_s = $signed(EXT_W'(w_reg[9:2]));

    // per-opcode walk setup
    logic signed [EXT_W-1:0] su_row;
    logic signed [EXT_W-1:0] su_row_last;
    logic [COL_W-1:0]        su_col_lo;
    logic [COL_W-1:0]        su_col_last;
    logic [1:0]              su_edge_lo;
    logic [1:0]              su_edge_hi;
    logic                    su_has_cols;
    logic                    su_colclip;
    logic                    su_active;
    logic                    su_clip;

    always_comb
    begin
        logic signed [EXT_W-1:0] cx0;
        logic signed [EXT_W-1:0] cx1;
        logic signed [EXT_W-1:0] cy0;
        logic signed [EXT_W-1:0] cy1;
        logic signed [EXT_W-1:0] cb0;
        logic signed [EXT_W-1:0] cb1;
        logic signed [EXT_W-1:0] lo;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] hi_m1;
        logic                    on;
        logic                    nz;

        cx0   = (x_reg < ZERO_S) ? ZERO_S : x_reg;
        cx1   = (x1_reg > VIS_W_S - ONE_S) ? VIS_W_S - ONE_S : x1_reg;
        cy0   = (y_reg < ZERO_S) ? ZERO_S : y_reg;
        cy1   = (y1_reg > HEIGHT_S - ONE_S) ? HEIGHT_S - ONE_S : y1_reg;
        cb0   = cx0 >>> 2;
        cb1   = cx1 >>> 2;
        lo    = (bx < ZERO_S) ? ZERO_S : ((bx > VIS_BYTES_S) ? VIS_BYTES_S : bx);
        hi    = (bxe_reg > VIS_BYTES_S) ? VIS_BYTES_S : bxe_reg;
        hi_m1 = hi - ONE_S;
        on    = (x_reg >= ZERO_S) && (x_reg < VIS_W_S) && (y_reg >= ZERO_S) && (y_reg < HEIGHT_S);
        nz    = (w_reg != '0) && (h_reg != '0);

        su_row      = y_reg;
        su_row_last = y_reg;
        su_col_lo   = bx[COL_W-1:0];
        su_col_last = bx[COL_W-1:0];
        su_edge_lo  = x_reg[1:0];
        su_edge_hi  = x_reg[1:0];
        su_has_cols = 1'b1;
        su_colclip  = 1'b0;
        su_active   = 1'b0;
        su_clip     = 1'b0;

        unique case (op_reg)
            OP_PIXEL, OP_READ:
            begin
                su_active = on;
                su_clip   = !on;
            end
            OP_FILL:
            begin
                su_row      = cy0;
                su_row_last = cy1;
                su_col_lo   = cb0[COL_W-1:0];
                su_col_last = cb1[COL_W-1:0];
                su_edge_lo  = cx0[1:0];
                su_edge_hi  = cx1[1:0];
                su_active   = nz && (cx0 <= cx1) && (cy0 <= cy1);
                su_clip     = nz && ((cx0 != x_reg) || (cx1 != x1_reg) ||
                                     (cy0 != y_reg) || (cy1 != y1_reg));
            end
            OP_INVERT:
            begin
                su_row      = ZERO_S;
                su_row_last = HEIGHT_S - ONE_S;
                su_col_lo   = '0;
                su_col_last = COL_W'(ROW_PITCH_BYTES - 1);
                su_edge_lo  = 2'd0;
                su_edge_hi  = 2'd3;
                su_active   = 1'b1;
            end
            OP_SCROLL:
            begin
                su_row      = y_reg;
                su_row_last = yl_reg;
                su_col_lo   = lo[COL_W-1:0];
                su_col_last = hi_m1[COL_W-1:0];
                su_edge_lo  = 2'd0;
                su_edge_hi  = 2'd3;
                su_has_cols = lo < hi;
                su_colclip  = (bx < ZERO_S) || (bxe_reg > VIS_BYTES_S);
                su_active   = (cnt_s != ZERO_S) && (y_reg <= yl_reg);
            end
            default:
            begin
                su_active = 1'b0;
                su_clip   = 1'b0;
            end
        endcase
    end

    // row checks and addressing
    logic signed [EXT_W-1:0] src_row;
    logic                    row_ok;
    logic [ROW_W-1:0]        row_u;
    logic [ROW_W-1:0]        src_u;
    logic [1:0]              lb;
    logic [1:0]              rb;
    logic [7:0]              mask;
    logic [7:0]              new_val;
    logic [7:0]              wbyte;

    assign src_row = row_reg + dy_s;
    assign row_ok  = (row_reg >= ZERO_S) && (row_reg < HEIGHT_S) &&
                     ((op_reg != OP_SCROLL) || ((src_row >= ZERO_S) && (src_row < HEIGHT_S)));
    assign row_u   = row_reg[ROW_W-1:0];
    assign src_u   = src_row[ROW_W-1:0];

    assign lb   = (col_reg == col_lo_reg) ? edge_lo_reg : 2'd0;
    assign rb   = (col_reg == col_last_reg) ? edge_hi_reg : 2'd3;
    assign mask = edge_mask(lb, rb);

    always_comb
    begin
        unique case (op_reg)
            OP_INVERT: new_val = ~ram_rdata;
            OP_SCROLL: new_val = ram_rdata;
            default:   new_val = color_reg ? PIX_ON_BYTE : 8'h00;
        endcase
    end

    assign wbyte = (ram_rdata & ~mask) | (new_val & mask);

    assign ram_re    = cmd.mem_rd;
    assign ram_raddr = ((op_reg == OP_SCROLL) ? src_base_reg : dst_base_reg) + ADDR_W'(col_reg);
    assign ram_we    = cmd.mem_wr && (op_reg != OP_READ);
    assign ram_waddr = dst_base_reg + ADDR_W'(col_reg);
    assign ram_wdata = wbyte;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.setup_b)
            begin
                active_reg <= su_active;
                clip_reg   <= su_clip;
            end
            else if (cmd.row_eval && (!row_ok || colclip_reg))
            begin
                clip_reg <= 1'b1;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode_t'(s_tdata[2:0]);
            x_reg     <= x_sum;
            y_reg     <= y_sum;
            w_reg     <= s_tdata[56:47];
            h_reg     <= s_tdata[66:57];
            color_reg <= s_tdata[67];
            dy_reg    <= s_tdata[75:68];
        end

        if (cmd.setup_a)
        begin
            x1_reg  <= x_reg + w_s - ONE_S;
            y1_reg  <= y_reg + h_s - ONE_S;
            bxe_reg <= bx + cnt_s;
            yl_reg  <= y_reg + h_s - dy_s - ONE_S;
        end

        if (cmd.setup_b)
        begin
            row_last_reg <= su_row_last;
            col_lo_reg   <= su_col_lo;
            col_last_reg <= su_col_last;
            edge_lo_reg  <= su_edge_lo;
            edge_hi_reg  <= su_edge_hi;
            has_cols_reg <= su_has_cols;
            colclip_reg  <= su_colclip;
        end

        priority if (cmd.setup_b)
        begin
            row_reg <= su_row;
        end
        else if (cmd.row_step)
        begin
            row_reg <= row_reg + ONE_S;
        end

        if (cmd.row_eval)
        begin
            dst_base_reg <= ADDR_W'(row_u) * ADDR_W'(ROW_PITCH_BYTES);
            src_base_reg <= ADDR_W'(src_u) * ADDR_W'(ROW_PITCH_BYTES);
        end

        priority if (cmd.row_eval)
        begin
            col_reg <= col_lo_reg;
        end
        else if (cmd.col_step)
        begin
            col_reg <= col_reg + 1'b1;
        end

        if (cmd.mem_wr && (op_reg == OP_READ))
        begin
            rd_reg <= ram_rdata;
        end

        if (cmd.finish)
        begin
            out_rd_reg   <= ((op_reg == OP_READ) && !clip_reg) ? rd_reg : 8'h00;
            out_clip_reg <= clip_reg;
        end
    end

    assign status.active   = active_reg;
    assign status.row_ok   = row_ok;
    assign status.has_cols = has_cols_reg;
    assign status.last_row = (row_reg == row_last_reg);
    assign status.last_col = (col_reg == col_last_reg);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_clip_reg, out_rd_reg};

endmodule

### hw/rtl/packed_pixel_raster_engine_unit.sv
// packed_pixel_raster_engine_unit: top level of the packed-pixel raster engine
// depends on ppre_pkg, ppre_ctrl, ppre_datapath and ppre_ram
//
// usage:
// - s channel takes one drawing command per item (pixel, fill rectangle, invert all,
//   scroll up, read byte); m channel returns one result item per command
// - the frame store packs four 2-bit pixels per byte, leftmost pixel in the high bits,
//   ROW_PITCH_BYTES * SCREEN_HEIGHT bytes in one ram with a registered read port
// - one command is worked at a time; each touched byte is read on the read port (ST_READ)
//   and, except for read commands, written back on the write port (ST_WRITE), each walked
//   row takes a ST_ROW step, and setup and hand-off go through ST_SETUP_A, ST_SETUP_B, ST_FINISH
// - a new item is taken as soon as the previous one is finished, even while its result
//   still sits in the output register; a stalled receiver holds the finished item
//   until the output register is free
// - reset clears the sequencer and the output valid; the store content is undefined
//   until written, and software fills it before reading; the block does not enforce this

module packed_pixel_raster_engine_unit
    import ppre_pkg::*;
#(
    parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
    parameter int ROW_PITCH_BYTES = DEF_ROW_PITCH_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode, origin_x, origin_y, pos_x, pos_y, rect_width, rect_height, color, scroll_rows
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_data, clipped
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH  = ROW_PITCH_BYTES * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    ppre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppre_datapath #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .ROW_PITCH_BYTES (ROW_PITCH_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ppre_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
